### rtl/core/transform_chain_world_position_defines.svh
// assertion macros used by tcwp_back
`ifndef TRANSFORM_CHAIN_WORLD_POSITION_DEFINES_SVH
`define TRANSFORM_CHAIN_WORLD_POSITION_DEFINES_SVH

// a implies b on the same edge
`define TCWP_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b on the next edge
`define TCWP_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

### rtl/core/tcwp_pkg.sv
`default_nettype none
package tcwp_pkg;
    localparam int unsigned IdxW = 9;
    localparam int unsigned DataW = 32;

    typedef enum logic [1:0] {
        OP_LOAD_TRANS = 2'd0,
        OP_LOAD_ROT = 2'd1,
        OP_LOAD_SCALE = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef struct packed {
        t_op op;
        logic in_range;
        logic signed [IdxW-1:0] entry_index;
        logic signed [IdxW-1:0] parent_index;
        logic signed [DataW-1:0] vx;
        logic signed [DataW-1:0] vy;
        logic signed [DataW-1:0] vz;
        logic signed [DataW-1:0] vw;
    } t_cmd;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [71:0] v);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        hi = 72'sd2147483647;
        lo = -72'sd2147483648;
        if (v > hi) sat32 = 32'sh7fffffff;
        else if (v < lo) sat32 = 32'sh80000000;
        else sat32 = v[DataW-1:0];
    endfunction
endpackage
`default_nettype wire

### rtl/core/transform_chain_world_position.sv
`default_nettype none
// World position of a node in a table of transform nodes. Loads (operation 0..2)
// write one part of a node; a query walks the parent chain, up to MAX_LEVELS
// levels, and returns the Q16.16 world position. One shared 32x32 multiplier
// does all products: each level takes 3 scale, 9 quaternion and 11 rotate
// steps plus memory read and bookkeeping. A two entry queue decouples the
// input from the walker; memories need no clearing after reset.
module transform_chain_world_position #(
    parameter int unsigned NODE_ENTRIES = 256,
    parameter int unsigned MAX_LEVELS = 60
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_ready,
    input  wire logic [1:0] i_operation,
    input  wire logic signed [8:0] i_entry_index,
    input  wire logic signed [8:0] i_parent_index,
    input  wire logic signed [31:0] i_value_x,
    input  wire logic signed [31:0] i_value_y,
    input  wire logic signed [31:0] i_value_z,
    input  wire logic signed [31:0] i_value_w,
    output logic o_valid,
    input  wire logic i_ready,
    output logic signed [31:0] o_world_x,
    output logic signed [31:0] o_world_y,
    output logic signed [31:0] o_world_z
);
    logic w_cmd_valid, w_cmd_ready;
    tcwp_pkg::t_cmd w_cmd;

    tcwp_front #(.NODE_ENTRIES(NODE_ENTRIES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_entry_index(i_entry_index),
        .i_parent_index(i_parent_index), .i_value_x(i_value_x),
        .i_value_y(i_value_y), .i_value_z(i_value_z), .i_value_w(i_value_w),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    tcwp_back #(.NODE_ENTRIES(NODE_ENTRIES), .MAX_LEVELS(MAX_LEVELS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cmd_valid),
        .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd), .o_valid(o_valid),
        .i_ready(i_ready), .o_world_x(o_world_x), .o_world_y(o_world_y),
        .o_world_z(o_world_z)
    );
endmodule
`default_nettype wire

### rtl/core/tcwp_front.sv
`default_nettype none
module tcwp_front #(
    parameter int unsigned NODE_ENTRIES = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic o_ready,
    input  wire logic [1:0] i_operation,
    input  wire logic signed [tcwp_pkg::IdxW-1:0] i_entry_index,
    input  wire logic signed [tcwp_pkg::IdxW-1:0] i_parent_index,
    input  wire logic signed [31:0] i_value_x,
    input  wire logic signed [31:0] i_value_y,
    input  wire logic signed [31:0] i_value_z,
    input  wire logic signed [31:0] i_value_w,
    output logic o_cmd_valid,
    input  wire logic i_cmd_ready,
    output tcwp_pkg::t_cmd o_cmd
);
    // two entry queue between the front and the back
    tcwp_pkg::t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic n_push, n_pop;
    tcwp_pkg::t_cmd n_cmd;

    always_comb begin
        n_cmd.op = tcwp_pkg::t_op'(i_operation);
        n_cmd.in_range = !i_entry_index[tcwp_pkg::IdxW-1]
            && (32'(unsigned'(i_entry_index)) < NODE_ENTRIES);
        n_cmd.entry_index = i_entry_index;
        n_cmd.parent_index = i_parent_index;
        n_cmd.vx = i_value_x;
        n_cmd.vy = i_value_y;
        n_cmd.vz = i_value_z;
        n_cmd.vw = i_value_w;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];
    assign n_push = i_valid && o_ready;
    assign n_pop = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (n_push) r_q[r_wp] <= n_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_push) r_wp <= !r_wp;
            if (n_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(n_push) - 2'(n_pop);
        end
    end
endmodule
`default_nettype wire

### rtl/core/tcwp_back.sv
`default_nettype none
`include "transform_chain_world_position_defines.svh"
module tcwp_back #(
    parameter int unsigned NODE_ENTRIES = 256,
    parameter int unsigned MAX_LEVELS = 60
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    output logic o_cmd_ready,
    input  wire tcwp_pkg::t_cmd i_cmd,
    output logic o_valid,
    input  wire logic i_ready,
    output logic signed [31:0] o_world_x,
    output logic signed [31:0] o_world_y,
    output logic signed [31:0] o_world_z
);
    localparam int unsigned AW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;
    localparam int unsigned LW = $clog2(MAX_LEVELS + 1);
    localparam int unsigned MW = 72;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RD    = 9'b000000010,
        ST_LOAD  = 9'b000000100,
        ST_SCALE = 9'b000001000,
        ST_COEF  = 9'b000010000,
        ST_CSUM  = 9'b000100000,
        ST_ROT   = 9'b001000000,
        ST_ACC   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    // node storage, one wide word per part
    logic [3*32+tcwp_pkg::IdxW-1:0] r_tmem [NODE_ENTRIES];
    logic [127:0] r_qmem [NODE_ENTRIES];
    logic [95:0] r_smem [NODE_ENTRIES];
    logic [3*32+tcwp_pkg::IdxW-1:0] r_trd;
    logic [127:0] r_qrd;
    logic [95:0] r_srd;

    t_state r_state;
    logic [AW-1:0] r_addr;
    logic r_first;
    logic [LW-1:0] r_level;
    logic [3:0] r_step;
    logic signed [31:0] r_p [3];
    logic signed [31:0] r_s [3];
    logic signed [31:0] r_q [4];
    logic signed [31:0] r_t [3];
    logic signed [tcwp_pkg::IdxW-1:0] r_par;
    logic signed [MW-1:0] r_tw [9];
    logic signed [31:0] r_c [9];
    logic signed [MW-1:0] r_acc [3];
    logic r_ovalid;
    logic signed [31:0] r_ox, r_oy, r_oz;

    logic signed [63:0] n_prod;
    logic signed [31:0] n_ma, n_mb;
    logic n_wr;
    logic n_par_ok;

    assign o_cmd_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_world_x = r_ox;
    assign o_world_y = r_oy;
    assign o_world_z = r_oz;
    assign n_wr = i_cmd_valid && o_cmd_ready && i_cmd.in_range
        && (i_cmd.op != tcwp_pkg::OP_QUERY);
    assign n_par_ok = !r_par[tcwp_pkg::IdxW-1]
        && (32'(unsigned'(r_par)) < NODE_ENTRIES) && (32'(r_level) < MAX_LEVELS);

    // one shared multiplier; step picks operands
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        unique case (r_state)
            ST_SCALE: begin
                n_ma = r_p[r_step[1:0]];
                n_mb = r_s[r_step[1:0]];
            end
            ST_COEF: begin
                unique case (r_step)
                    4'd0: begin n_ma = r_q[1]; n_mb = r_q[1]; end
                    4'd1: begin n_ma = r_q[2]; n_mb = r_q[2]; end
                    4'd2: begin n_ma = r_q[0]; n_mb = r_q[0]; end
                    4'd3: begin n_ma = r_q[0]; n_mb = r_q[1]; end
                    4'd4: begin n_ma = r_q[3]; n_mb = r_q[2]; end
                    4'd5: begin n_ma = r_q[0]; n_mb = r_q[2]; end
                    4'd6: begin n_ma = r_q[3]; n_mb = r_q[1]; end
                    4'd7: begin n_ma = r_q[1]; n_mb = r_q[2]; end
                    4'd8: begin n_ma = r_q[3]; n_mb = r_q[0]; end
                    default: begin n_ma = '0; n_mb = '0; end
                endcase
            end
            ST_ROT: begin
                n_ma = r_s[r_step[1:0]];
                unique case (r_step)
                    4'd0: n_mb = r_c[0]; 4'd1: n_mb = r_c[1]; 4'd2: n_mb = r_c[2];
                    4'd4: n_mb = r_c[3]; 4'd5: n_mb = r_c[4]; 4'd6: n_mb = r_c[5];
                    4'd8: n_mb = r_c[6]; 4'd9: n_mb = r_c[7]; 4'd10: n_mb = r_c[8];
                    default: n_mb = '0;
                endcase
                n_ma = r_s[r_step[1:0]];
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
        n_prod = 64'(n_ma) * 64'(n_mb);
    end

    always_ff @(posedge i_clk) begin
        if (n_wr) begin
            unique case (i_cmd.op)
                tcwp_pkg::OP_LOAD_TRANS: r_tmem[i_cmd.entry_index[AW-1:0]] <=
                    {i_cmd.vx, i_cmd.vy, i_cmd.vz, i_cmd.parent_index};
                tcwp_pkg::OP_LOAD_ROT: r_qmem[i_cmd.entry_index[AW-1:0]] <=
                    {i_cmd.vx, i_cmd.vy, i_cmd.vz, i_cmd.vw};
                tcwp_pkg::OP_LOAD_SCALE: r_smem[i_cmd.entry_index[AW-1:0]] <=
                    {i_cmd.vx, i_cmd.vy, i_cmd.vz};
                default: ;
            endcase
        end
        r_trd <= r_tmem[r_addr];
        r_qrd <= r_qmem[r_addr];
        r_srd <= r_smem[r_addr];

        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && o_cmd_ready && i_cmd.op == tcwp_pkg::OP_QUERY) begin
                        if (i_cmd.in_range) begin
                            r_addr <= i_cmd.entry_index[AW-1:0];
                            r_first <= 1'b1;
                            r_level <= '0;
                            r_state <= ST_RD;
                        end else begin
                            r_ox <= '0;
                            r_oy <= '0;
                            r_oz <= '0;
                            r_ovalid <= 1'b1;
                        end
                    end
                end
                ST_RD: r_state <= ST_LOAD;
                ST_LOAD: begin
                    r_par <= r_trd[tcwp_pkg::IdxW-1:0];
                    r_step <= '0;
                    if (r_first) begin
                        r_p[0] <= r_trd[tcwp_pkg::IdxW+95 -: 32];
                        r_p[1] <= r_trd[tcwp_pkg::IdxW+63 -: 32];
                        r_p[2] <= r_trd[tcwp_pkg::IdxW+31 -: 32];
                        r_first <= 1'b0;
                        r_state <= ST_ACC;
                    end else begin
                        r_t[0] <= r_trd[tcwp_pkg::IdxW+95 -: 32];
                        r_t[1] <= r_trd[tcwp_pkg::IdxW+63 -: 32];
                        r_t[2] <= r_trd[tcwp_pkg::IdxW+31 -: 32];
                        r_q[0] <= r_qrd[127:96];
                        r_q[1] <= r_qrd[95:64];
                        r_q[2] <= r_qrd[63:32];
                        r_q[3] <= r_qrd[31:0];
                        r_s[0] <= r_srd[95:64];
                        r_s[1] <= r_srd[63:32];
                        r_s[2] <= r_srd[31:0];
                        r_level <= r_level + 1'b1;
                        r_state <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    r_s[r_step[1:0]] <= tcwp_pkg::sat32(MW'(n_prod >>> 16));
                    if (r_step == 4'd2) begin
                        r_step <= '0;
                        r_state <= ST_COEF;
                    end else r_step <= r_step + 1'b1;
                end
                ST_COEF: begin
                    r_tw[r_step] <= MW'(n_prod >>> 29);
                    if (r_step == 4'd8) begin
                        r_state <= ST_CSUM;
                    end else r_step <= r_step + 1'b1;
                end
                ST_CSUM: begin
                    // tw: yy zz xx xy wz xz wy yz wx
                    r_c[0] <= tcwp_pkg::sat32(-r_tw[0] - r_tw[1]);
                    r_c[1] <= tcwp_pkg::sat32(r_tw[3] - r_tw[4]);
                    r_c[2] <= tcwp_pkg::sat32(r_tw[5] + r_tw[6]);
                    r_c[3] <= tcwp_pkg::sat32(r_tw[3] + r_tw[4]);
                    r_c[4] <= tcwp_pkg::sat32(-r_tw[2] - r_tw[1]);
                    r_c[5] <= tcwp_pkg::sat32(r_tw[7] - r_tw[8]);
                    r_c[6] <= tcwp_pkg::sat32(r_tw[5] - r_tw[6]);
                    r_c[7] <= tcwp_pkg::sat32(r_tw[7] + r_tw[8]);
                    r_c[8] <= tcwp_pkg::sat32(-r_tw[2] - r_tw[0]);
                    r_acc[0] <= MW'(r_t[0]) + MW'(r_s[0]);
                    r_acc[1] <= MW'(r_t[1]) + MW'(r_s[1]);
                    r_acc[2] <= MW'(r_t[2]) + MW'(r_s[2]);
                    r_step <= '0;
                    r_state <= ST_ROT;
                end
                ST_ROT: begin
                    // step = row*4 + column
                    if (r_step[1:0] != 2'd3)
                        r_acc[r_step[3:2]] <= r_acc[r_step[3:2]] + MW'(n_prod >>> 30);
                    if (r_step == 4'd10) begin
                        r_p[0] <= tcwp_pkg::sat32(r_acc[0]);
                        r_p[1] <= tcwp_pkg::sat32(r_acc[1]);
                        r_p[2] <= tcwp_pkg::sat32(r_acc[2] + MW'(n_prod >>> 30));
                        r_state <= ST_ACC;
                    end else r_step <= r_step + 1'b1;
                end
                ST_ACC: begin
                    if (n_par_ok) begin
                        r_addr <= r_par[AW-1:0];
                        r_state <= ST_RD;
                    end else r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ovalid) begin
                        r_ox <= r_p[0];
                        r_oy <= r_p[1];
                        r_oz <= r_p[2];
                        r_ovalid <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `TCWP_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `TCWP_ASSERT_IMP(a_lvl, i_clk, i_rst_n, r_state != ST_IDLE, 32'(r_level) <= MAX_LEVELS)
    `TCWP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ovalid && !i_ready, r_ovalid && $stable(r_ox))
endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    typedef tcwp_pkg::t_op t_op;
    localparam t_op OP_LOAD_TRANS = tcwp_pkg::OP_LOAD_TRANS;
    localparam t_op OP_LOAD_ROT = tcwp_pkg::OP_LOAD_ROT;
    localparam t_op OP_LOAD_SCALE = tcwp_pkg::OP_LOAD_SCALE;
    localparam t_op OP_QUERY = tcwp_pkg::OP_QUERY;

    localparam int NODES = 256;
    localparam int LEVELS = 60;
    localparam int RANDOM_ITEMS = 1750;
    localparam int Q30_ONE = 32'sh40000000;
    localparam int Q16_ONE = 32'sh00010000;

    typedef struct {
        t_op op;
        logic signed [8:0] idx;
        logic signed [8:0] par;
        logic signed [31:0] vx, vy, vz, vw;
    } t_node_cmd;

    typedef struct {
        logic signed [31:0] x, y, z;
    } t_world_pos;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_operation = OP_LOAD_TRANS;
    logic signed [8:0] i_entry_index = '0;
    logic signed [8:0] i_parent_index = '0;
    logic signed [31:0] i_value_x = '0;
    logic signed [31:0] i_value_y = '0;
    logic signed [31:0] i_value_z = '0;
    logic signed [31:0] i_value_w = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [31:0] o_world_x, o_world_y, o_world_z;

    transform_chain_world_position dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_node_cmd pending_items[$];
    t_world_pos expected_pos[$];
    int errors = 0;
    int items_sent = 0;
    int queries_sent = 0;
    int results_seen = 0;
    int deepest_walk = 0;

    // generation-time shadow: which parts of each node are written, and parents
    bit gen_trans[NODES], gen_rot[NODES], gen_scale[NODES];
    int gen_parent[NODES];

    // predictor copy of the node table
    logic signed [31:0] tx[NODES], ty[NODES], tz[NODES];
    logic signed [31:0] qx[NODES], qy[NODES], qz[NODES], qw[NODES];
    logic signed [31:0] sx[NODES], sy[NODES], sz[NODES];
    logic signed [8:0] par_tab[NODES];

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint dbl(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 29;
    endfunction

    function automatic longint rot_term(logic signed [31:0] s, logic signed [31:0] c);
        longint p;
        p = longint'(s) * longint'(c);
        return p >>> 30;
    endfunction

    task automatic predict_node(input t_node_cmd it);
        int n, cur, lv;
        logic signed [31:0] px, py, pz, ax, ay, az;
        logic signed [31:0] cxx, cxy, cxz, cyx, cyy, cyz, czx, czy, czz;
        t_world_pos w;
        n = it.idx;
        if (it.op != OP_QUERY) begin
            if (n < 0) return;
            case (it.op)
                OP_LOAD_TRANS: begin
                    tx[n] = it.vx; ty[n] = it.vy; tz[n] = it.vz; par_tab[n] = it.par;
                end
                OP_LOAD_ROT: begin
                    qx[n] = it.vx; qy[n] = it.vy; qz[n] = it.vz; qw[n] = it.vw;
                end
                default: begin
                    sx[n] = it.vx; sy[n] = it.vy; sz[n] = it.vz;
                end
            endcase
            return;
        end
        px = 0; py = 0; pz = 0;
        if (n >= 0) begin
            px = tx[n]; py = ty[n]; pz = tz[n];
            cur = par_tab[n];
            lv = 0;
            while (cur >= 0 && lv < LEVELS) begin
                ax = clamp32((longint'(px) * longint'(sx[cur])) >>> 16);
                ay = clamp32((longint'(py) * longint'(sy[cur])) >>> 16);
                az = clamp32((longint'(pz) * longint'(sz[cur])) >>> 16);
                cxx = clamp32(-dbl(qy[cur], qy[cur]) - dbl(qz[cur], qz[cur]));
                cxy = clamp32(dbl(qx[cur], qy[cur]) - dbl(qw[cur], qz[cur]));
                cxz = clamp32(dbl(qx[cur], qz[cur]) + dbl(qw[cur], qy[cur]));
                cyx = clamp32(dbl(qx[cur], qy[cur]) + dbl(qw[cur], qz[cur]));
                cyy = clamp32(-dbl(qx[cur], qx[cur]) - dbl(qz[cur], qz[cur]));
                cyz = clamp32(dbl(qy[cur], qz[cur]) - dbl(qw[cur], qx[cur]));
                czx = clamp32(dbl(qx[cur], qz[cur]) - dbl(qw[cur], qy[cur]));
                czy = clamp32(dbl(qy[cur], qz[cur]) + dbl(qw[cur], qx[cur]));
                czz = clamp32(-dbl(qx[cur], qx[cur]) - dbl(qy[cur], qy[cur]));
                px = clamp32(longint'(tx[cur]) + ax + rot_term(ax, cxx)
                             + rot_term(ay, cxy) + rot_term(az, cxz));
                py = clamp32(longint'(ty[cur]) + ay + rot_term(ax, cyx)
                             + rot_term(ay, cyy) + rot_term(az, cyz));
                pz = clamp32(longint'(tz[cur]) + az + rot_term(ax, czx)
                             + rot_term(ay, czy) + rot_term(az, czz));
                cur = par_tab[cur];
                lv++;
            end
            if (lv > deepest_walk) deepest_walk = lv;
        end
        w.x = px; w.y = py; w.z = pz;
        expected_pos.push_back(w);
    endtask

    task automatic add_item(input t_op op, input int idx, input int par,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [31:0] w);
        t_node_cmd it;
        it.op = op; it.idx = idx; it.par = par;
        it.vx = x; it.vy = y; it.vz = z; it.vw = w;
        pending_items.push_back(it);
        if (op != OP_QUERY && idx >= 0) begin
            case (op)
                OP_LOAD_TRANS: begin gen_trans[idx] = 1; gen_parent[idx] = par; end
                OP_LOAD_ROT: gen_rot[idx] = 1;
                default: gen_scale[idx] = 1;
            endcase
        end
    endtask

    // a query may only touch entries that were written
    function automatic bit walk_is_defined(int n);
        int cur, lv;
        if (n < 0) return 1;
        if (!gen_trans[n]) return 0;
        cur = gen_parent[n];
        for (lv = 0; lv < LEVELS && cur >= 0; lv++) begin
            if (!(gen_trans[cur] && gen_rot[cur] && gen_scale[cur])) return 0;
            cur = gen_parent[cur];
        end
        return 1;
    endfunction

    function automatic logic [31:0] pick_value(bit is_quat);
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3, 4, 5: return $urandom_range(0, 32'h3ffff) - 32'h20000;
            6: return is_quat ? Q30_ONE - $urandom_range(0, 32'hfffff) : Q16_ONE;
            7: return 32'h7fffffff;
            8: return 32'h80000000;
            default: return is_quat ? $urandom_range(0, 32'h7fffffff) - 32'h3fffffff
                                    : $urandom_range(0, 32'h3ffff);
        endcase
    endfunction

    function automatic int pick_parent();
        int r, p, k;
        r = $urandom_range(0, 99);
        if (r < 35) return -1;
        if (r < 40) return -$urandom_range(1, 256);
        for (k = 0; k < 6; k++) begin
            p = $urandom_range(0, NODES - 1);
            if (gen_trans[p] && gen_rot[p] && gen_scale[p]) return p;
        end
        return -1;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_node_cmd it;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                it.op = t_op'(i_operation); it.idx = i_entry_index; it.par = i_parent_index;
                it.vx = i_value_x; it.vy = i_value_y; it.vz = i_value_z; it.vw = i_value_w;
                predict_node(it);
                items_sent++;
                if (it.op == OP_QUERY) queries_sent++;
            end
            if (pending_items.size() > 0 &&
                ((items_sent > 600 && items_sent < 900) || $urandom_range(0, 99) >= 17)) begin
                it = pending_items.pop_front();
                i_valid <= 1'b1;
                i_operation <= it.op;
                i_entry_index <= it.idx;
                i_parent_index <= it.par;
                i_value_x <= it.vx;
                i_value_y <= it.vy;
                i_value_z <= it.vz;
                i_value_w <= it.vw;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    int hold_left = 0;
    bit hold_done = 0;
    always @(posedge i_clk) begin
        t_world_pos w;
        bit rdy;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_pos.size() == 0) begin
                    $error("result with no query waiting: %h %h %h",
                           o_world_x, o_world_y, o_world_z);
                    errors++;
                end else begin
                    w = expected_pos.pop_front();
                    if (o_world_x !== w.x) begin
                        $error("world_x expected %h actual %h", w.x, o_world_x);
                        errors++;
                    end
                    if (o_world_y !== w.y) begin
                        $error("world_y expected %h actual %h", w.y, o_world_y);
                        errors++;
                    end
                    if (o_world_z !== w.z) begin
                        $error("world_z expected %h actual %h", w.z, o_world_z);
                        errors++;
                    end
                end
            end
            // one long hold-off so the input side backs up
            if (!hold_done && results_seen == 20) begin
                hold_done = 1;
                hold_left = 2000;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 0;
            end else if (results_seen > 100 && results_seen < 160) begin
                rdy = 1;
            end else begin
                rdy = $urandom_range(0, 99) >= 17;
            end
            i_ready <= rdy;
        end
    end

    initial begin
        int k, n, r, tries;
        bit found;
        for (k = 0; k < NODES; k++) gen_parent[k] = -1;

        // directed: extremes, identity, saturation, self loop, bad indexes
        add_item(OP_LOAD_TRANS, 0, -1, 32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff);
        add_item(OP_LOAD_ROT, 0, 0, 0, 0, 0, Q30_ONE);
        add_item(OP_LOAD_SCALE, 0, 0, Q16_ONE, Q16_ONE, Q16_ONE, 0);
        add_item(OP_QUERY, 0, 0, 0, 0, 0, 0);
        add_item(OP_LOAD_TRANS, 1, 0, 32'h80000000, 32'h7fffffff, 32'h12345678, 0);
        add_item(OP_LOAD_ROT, 1, -256, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
        add_item(OP_LOAD_SCALE, 1, 255, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
        add_item(OP_QUERY, 1, 0, 0, 0, 0, 0);
        add_item(OP_LOAD_TRANS, 2, 2, Q16_ONE, -Q16_ONE, 32'h00000100, 0);
        add_item(OP_LOAD_ROT, 2, 0, 0, 0, 0, Q30_ONE);
        add_item(OP_LOAD_SCALE, 2, 0, Q16_ONE, Q16_ONE, Q16_ONE, 0);
        add_item(OP_QUERY, 2, 0, 0, 0, 0, 0);
        add_item(OP_LOAD_TRANS, 255, 1, Q16_ONE, 0, 0, 0);
        add_item(OP_LOAD_ROT, 255, 0, 0, 0, 32'h2d413ccd, 32'h2d413ccd);
        add_item(OP_LOAD_SCALE, 255, 0, 32'h00020000, 32'h00008000, 32'hffff0000, 0);
        add_item(OP_QUERY, 255, 0, 0, 0, 0, 0);
        add_item(OP_QUERY, -1, 0, 0, 0, 0, 0);
        add_item(OP_QUERY, -256, -1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        add_item(OP_LOAD_TRANS, -5, 7, 32'hdeadbeef, 0, 0, 0);
        add_item(OP_LOAD_ROT, -256, 0, 0, 0, 0, 0);
        add_item(OP_LOAD_SCALE, -1, 0, 0, 0, 0, 0);
        add_item(OP_QUERY, 2, 0, 0, 0, 0, 0);

        // random: mostly whole node builds, some single-part rewrites and queries
        while (pending_items.size() < RANDOM_ITEMS + 22) begin
            r = $urandom_range(0, 99);
            if (r < 22) begin
                found = 0;
                n = -1;
                for (tries = 0; tries < 8 && !found; tries++) begin
                    n = $urandom_range(0, NODES - 1);
                    found = walk_is_defined(n);
                end
                if (!found || r < 2) n = -$urandom_range(1, 256);
                add_item(OP_QUERY, n, $urandom_range(0, 511) - 256, $urandom, $urandom,
                         $urandom, $urandom);
            end else if (r < 30) begin
                n = (r < 24) ? -$urandom_range(1, 256) : $urandom_range(0, NODES - 1);
                add_item(t_op'($urandom_range(0, 2)), n, pick_parent(), pick_value(r[0]),
                         pick_value(r[0]), pick_value(r[0]), pick_value(1));
            end else begin
                n = $urandom_range(0, NODES - 1);
                add_item(OP_LOAD_TRANS, n, pick_parent(), pick_value(0), pick_value(0),
                         pick_value(0), $urandom);
                add_item(OP_LOAD_ROT, n, $urandom_range(0, 511) - 256, pick_value(1),
                         pick_value(1), pick_value(1), pick_value(1));
                add_item(OP_LOAD_SCALE, n, $urandom_range(0, 511) - 256, pick_value(0),
                         pick_value(0), pick_value(0), $urandom);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0);
        @(posedge i_clk);
        wait (!i_valid);
        wait (expected_pos.size() == 0);
        repeat (200) @(posedge i_clk);
        if (expected_pos.size() != 0) begin
            $error("%0d world positions never arrived", expected_pos.size());
            errors++;
        end
        $display("items %0d, queries %0d, results %0d, deepest walk %0d levels",
                 items_sent, queries_sent, results_seen, deepest_walk);
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
